@@ hw/rtl/humidity_frame_check_convert_assert.svh @@
// Assertion macros for the verification files of the humidity frame block.
// Depends on nothing; included by the checker module.
`ifndef HUMIDITY_FRAME_CHECK_CONVERT_ASSERT_SVH
`define HUMIDITY_FRAME_CHECK_CONVERT_ASSERT_SVH

// Checks that an expression holds at every clock edge outside reset.
`define HFCC_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("hfcc assertion failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define HFCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hfcc assertion failed");

`endif

@@ hw/rtl/hfcc_pkg.sv @@
// Package of the humidity frame check and convert block: types, codes and constants.
// Depends on nothing; used by every RTL module of the block.
`default_nettype none

package hfcc_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_BAD = 2'd1,
        ST_HUM_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] raw_temperature;
        logic [15:0] raw_humidity;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } t_back_state;

    typedef enum logic [1:0] {
        CV_FAHRENHEIT = 2'd0,
        CV_CELSIUS    = 2'd1,
        CV_HUMIDITY   = 2'd2
    } t_conv;

    localparam logic [30:0] ROUND_BIAS  = 31'd32767;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;
    localparam logic [15:0] F_OFFSET    = 16'd4900;
    localparam logic [14:0] C_OFFSET    = 15'd4500;
    localparam logic [14:0] HUM_MAX     = 15'd10000;

    function automatic logic [14:0] scale_k(input t_conv sel);
        logic [14:0] k;
        case (sel)
            CV_FAHRENHEIT: k = 15'd31500;
            CV_CELSIUS:    k = 15'd17500;
            CV_HUMIDITY:   k = 15'd10000;
            default:       k = 15'd0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hfcc_if.sv @@
// Channel interfaces of the humidity frame block: received bytes and results.
// Depends on nothing.
`default_nettype none

interface hfcc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source(output valid, rx_byte, frame_start, input ready);
    modport sink(input valid, rx_byte, frame_start, output ready);
endinterface

interface hfcc_res_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic        [15:0] raw_temperature;
    logic        [15:0] raw_humidity;
    logic signed [15:0] temp_f_centi;
    logic signed [14:0] temp_c_centi;
    logic        [13:0] humidity_centi;

    modport source(output valid, status, raw_temperature, raw_humidity, temp_f_centi,
                   temp_c_centi, humidity_centi, input ready);
    modport sink(input valid, status, raw_temperature, raw_humidity, temp_f_centi,
                 temp_c_centi, humidity_centi, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/humidity_frame_check_convert.sv @@
// Top level of the humidity frame block: front end, job queue and conversion back end.
// Depends on hfcc_pkg, hfcc_if, hfcc_front, hfcc_queue and hfcc_back.
//
// The block takes the six bytes of a sensor measurement reply, one byte per transaction,
// checks the CRC-8 of the temperature and humidity words and gives one result per reply.
// The byte input takes one transaction per cycle while the queue has room. The back end
// loads each job in its idle state, runs each of the three conversions through the one
// shared 15 by 16 bit multiplier and its divide-by-65535 correction, and holds the result
// until it is taken; only then does it take the next job. The queue lets the next reply's
// bytes arrive while a result waits.
`default_nettype none

module humidity_frame_check_convert #(
    parameter int QUEUE_DEPTH = hfcc_pkg::QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    hfcc_byte_if.sink  i_byte,
    hfcc_res_if.source o_result
);
    import hfcc_pkg::*;

    logic push_valid;
    t_job push_job;
    logic full;
    logic pop_valid;
    logic pop_ready;
    t_job pop_job;

    hfcc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .i_full       (full),
        .o_push_valid (push_valid),
        .o_push_job   (push_job)
    );

    hfcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_job   (push_job),
        .o_full       (full),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    hfcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .i_job       (pop_job),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

@@ hw/rtl/hfcc_front.sv @@
// Front end: tracks the frame position, checks both CRC-8 bytes and collects the words.
// Depends on hfcc_pkg and hfcc_if; pushes one job per frame into the queue.
`default_nettype none

module hfcc_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    hfcc_byte_if.sink      i_byte,
    input  wire            i_full,
    output logic           o_push_valid,
    output hfcc_pkg::t_job o_push_job
);
    import hfcc_pkg::*;

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;
    localparam logic [7:0] CRC_INIT  = 8'hFF;
    localparam logic [7:0] CRC_POLY  = 8'h31;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_tw, n_tw;
    logic [15:0] r_hw, n_hw;
    logic        r_t_ok, n_t_ok;
    logic [2:0]  pos;
    logic [7:0]  crc_in;
    logic        accept;

    assign i_byte.ready = !i_full;
    assign accept = i_byte.valid && !i_full;
    assign pos = (i_byte.frame_start || r_pos > POS_H_CRC) ? POS_T_HI : r_pos;
    assign crc_in = (pos == POS_T_HI || pos == POS_H_HI) ? CRC_INIT : r_crc;

    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_tw   = r_tw;
        n_hw   = r_hw;
        n_t_ok = r_t_ok;
        if (accept) begin
            case (pos)
                POS_T_HI: begin
                    n_tw[15:8] = i_byte.rx_byte;
                    n_crc = crc_feed(crc_in, i_byte.rx_byte);
                    n_pos = POS_T_LO;
                end
                POS_T_LO: begin
                    n_tw[7:0] = i_byte.rx_byte;
                    n_crc = crc_feed(crc_in, i_byte.rx_byte);
                    n_pos = POS_T_CRC;
                end
                POS_T_CRC: begin
                    n_t_ok = (crc_in == i_byte.rx_byte);
                    n_crc = crc_in;
                    n_pos = POS_H_HI;
                end
                POS_H_HI: begin
                    n_hw[15:8] = i_byte.rx_byte;
                    n_crc = crc_feed(crc_in, i_byte.rx_byte);
                    n_pos = POS_H_LO;
                end
                POS_H_LO: begin
                    n_hw[7:0] = i_byte.rx_byte;
                    n_crc = crc_feed(crc_in, i_byte.rx_byte);
                    n_pos = POS_H_CRC;
                end
                default: begin
                    n_crc = CRC_INIT;
                    n_pos = POS_T_HI;
                end
            endcase
        end
    end

    always_comb begin
        o_push_valid = accept && (pos == POS_H_CRC);
        o_push_job.raw_temperature = r_tw;
        o_push_job.raw_humidity = r_hw;
        if (!r_t_ok) begin
            o_push_job.status = ST_TEMP_BAD;
        end else if (crc_in != i_byte.rx_byte) begin
            o_push_job.status = ST_HUM_BAD;
        end else begin
            o_push_job.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_T_HI;
            r_crc  <= CRC_INIT;
            r_tw   <= '0;
            r_hw   <= '0;
            r_t_ok <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_tw   <= n_tw;
            r_hw   <= n_hw;
            r_t_ok <= n_t_ok;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/hfcc_queue.sv @@
// Short job queue between the front end and the conversion back end.
// Depends on hfcc_pkg for the job type.
`default_nettype none

module hfcc_queue #(
    parameter int DEPTH = hfcc_pkg::QUEUE_DEPTH
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push_valid,
    input  hfcc_pkg::t_job i_push_job,
    output logic           o_full,
    output logic           o_pop_valid,
    input  wire            i_pop_ready,
    output hfcc_pkg::t_job o_pop_job
);
    import hfcc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_job   = r_mem[r_rd_ptr];
    assign push        = i_push_valid && !o_full;
    assign pop         = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/hfcc_back.sv @@
// Back end: converts the raw words with one shared multiplier and holds the result.
// Depends on hfcc_pkg and hfcc_if; pops jobs from the queue.
`default_nettype none

module hfcc_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_job_valid,
    output logic           o_job_ready,
    input  hfcc_pkg::t_job i_job,
    hfcc_res_if.source     o_result
);
    import hfcc_pkg::*;

    t_back_state r_state, n_state;
    t_conv       r_conv, n_conv;
    t_job        r_job;
    logic [30:0] r_prod;
    logic [15:0] r_tf;
    logic [14:0] r_tc;
    logic [13:0] r_hum;
    logic [15:0] raw_sel;
    logic [14:0] q0;
    logic [16:0] rem;
    logic [14:0] quot;

    assign raw_sel = (r_conv == CV_HUMIDITY) ? r_job.raw_humidity : r_job.raw_temperature;

    // The quotient by 65535 is the upper half plus a correction of at most one.
    assign q0   = r_prod[30:16];
    assign rem  = {1'b0, r_prod[15:0]} + 17'(q0);
    assign quot = q0 + 15'(rem >= FULL_SCALE);

    always_comb begin
        n_state = r_state;
        n_conv  = r_conv;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = BK_MUL;
                    n_conv  = CV_FAHRENHEIT;
                end
            end
            BK_MUL: n_state = BK_DIV;
            BK_DIV: begin
                case (r_conv)
                    CV_FAHRENHEIT: begin
                        n_conv  = CV_CELSIUS;
                        n_state = BK_MUL;
                    end
                    CV_CELSIUS: begin
                        n_conv  = CV_HUMIDITY;
                        n_state = BK_MUL;
                    end
                    default: n_state = BK_DONE;
                endcase
            end
            BK_DONE: begin
                if (o_result.ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready                 = (r_state == BK_IDLE);
        o_result.valid              = (r_state == BK_DONE);
        o_result.status             = r_job.status;
        o_result.raw_temperature    = r_job.raw_temperature;
        o_result.raw_humidity       = r_job.raw_humidity;
        o_result.temp_f_centi       = r_tf;
        o_result.temp_c_centi       = r_tc;
        o_result.humidity_centi     = r_hum;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_IDLE && i_job_valid) begin
            r_job <= i_job;
        end
        if (r_state == BK_MUL) begin
            r_prod <= 31'(scale_k(r_conv)) * 31'(raw_sel) + ROUND_BIAS;
        end
        if (r_state == BK_DIV) begin
            case (r_conv)
                CV_FAHRENHEIT: r_tf <= {1'b0, quot} - F_OFFSET;
                CV_CELSIUS:    r_tc <= quot - C_OFFSET;
                default:       r_hum <= (quot > HUM_MAX) ? HUM_MAX[13:0] : quot[13:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_conv  <= CV_FAHRENHEIT;
        end else begin
            r_state <= n_state;
            r_conv  <= n_conv;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/hfcc_checker.sv @@
// Port-level checker of the humidity frame block and the bind that attaches it.
// Depends on humidity_frame_check_convert_assert.svh and the top level.
`default_nettype none

`include "humidity_frame_check_convert_assert.svh"

module hfcc_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_valid,
    input wire               i_ready,
    input wire        [1:0]  i_status,
    input wire        [15:0] i_raw_t,
    input wire        [15:0] i_raw_h,
    input wire signed [15:0] i_tf,
    input wire signed [14:0] i_tc,
    input wire        [13:0] i_hum
);

    logic [78:0] payload;

    assign payload = {i_status, i_raw_t, i_raw_h, i_tf, i_tc, i_hum};

    // A result that is not taken stays offered and unchanged.
    `HFCC_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, i_valid && !i_ready, i_valid)
    `HFCC_ASSERT_NEXT(a_payload_holds, i_clk, i_rst_n, i_valid && !i_ready, $stable(payload))

    // Converted values stay within the sensor's range.
    `HFCC_ASSERT(a_hum_range, i_clk, i_rst_n, !i_valid || i_hum <= 14'd10000)
    `HFCC_ASSERT(a_tf_range, i_clk, i_rst_n, !i_valid || (i_tf >= -16'sd4900 && i_tf <= 16'sd26600))
    `HFCC_ASSERT(a_tc_range, i_clk, i_rst_n, !i_valid || (i_tc >= -15'sd4500 && i_tc <= 15'sd13000))

endmodule

bind humidity_frame_check_convert hfcc_checker u_hfcc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_result.valid),
    .i_ready (o_result.ready),
    .i_status(o_result.status),
    .i_raw_t (o_result.raw_temperature),
    .i_raw_h (o_result.raw_humidity),
    .i_tf    (o_result.temp_f_centi),
    .i_tc    (o_result.temp_c_centi),
    .i_hum   (o_result.humidity_centi)
);

`default_nettype wire
